[src/sfrbs_pkg.sv]
// ----------------------------------------------------------------------------
// sfrbs_pkg: shared types and constants of the sync frame receiver
// Frame geometry, sync bytes, state types and the frame store write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfrbs_pkg;

  localparam int FRAME_BYTES = 68;
  localparam int LANES       = 4;
  localparam int GROUPS      = FRAME_BYTES / LANES;
  localparam int POS_W       = 7;
  localparam int GRP_W       = 5;
  localparam int LANE_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int TDATA_W     = 40;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
  localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(FRAME_BYTES - 1);
  localparam logic [GRP_W-1:0]  LAST_GRP    = GRP_W'(GROUPS - 1);
  // Groups from this index upward swap within 16-bit halves, like group 0.
  localparam logic [GRP_W-1:0]  HALF_FROM   = GRP_W'((FRAME_BYTES - 8) / LANES);

  typedef enum logic {
    RX_HUNT,
    RX_FRAME
  } rx_state_e;

  typedef enum logic {
    EM_IDLE,
    EM_RUN
  } em_state_e;

  typedef struct packed {
    logic                  we;
    logic [LANE_W-1:0]     lane;
    logic [GRP_W-1:0]      addr;
    logic [BYTE_W-1:0]     data;
  } wr_t;

endpackage

[src/sfrbs_ram.sv]
// ----------------------------------------------------------------------------
// sfrbs_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfrbs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 17,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/sfrbs_rx_ctrl.sv]
// ----------------------------------------------------------------------------
// sfrbs_rx_ctrl: sync hunt and frame fill
// Hunts for the sync pair, writes each frame byte into the store and flags
// the completion of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfrbs_rx_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sfrbs_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic                            line_error_i,
  input  logic                            busy_i,
  output sfrbs_pkg::wr_t                  wr_o,
  output logic                            start_o
);

  sfrbs_pkg::rx_state_e             state_q, state_d;
  logic                             header_q, header_d;
  logic [sfrbs_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [sfrbs_pkg::POS_W-1:0]      pos_inc;
  logic                             accept;

  assign s_axis_tready = !busy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = sfrbs_pkg::POS_W'(pos_q + 1'b1);

  // Next state.
  always_comb begin
    state_d  = state_q;
    header_d = header_q;
    pos_d    = pos_q;
    if (accept) begin
      if (line_error_i) begin
        state_d = sfrbs_pkg::RX_HUNT;
        pos_d   = '0;
      end else begin
        case (state_q)
          sfrbs_pkg::RX_HUNT: begin
            if (rx_byte_i == sfrbs_pkg::SYNC_FIRST) begin
              header_d = 1'b1;
              pos_d    = '0;
            end else if (rx_byte_i == sfrbs_pkg::SYNC_SECOND && header_q) begin
              state_d = sfrbs_pkg::RX_FRAME;
              pos_d   = pos_inc;
            end
          end
          sfrbs_pkg::RX_FRAME: begin
            if (pos_inc == sfrbs_pkg::LAST_POS) begin
              state_d  = sfrbs_pkg::RX_HUNT;
              header_d = 1'b0;
              pos_d    = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
          default: begin
            state_d = sfrbs_pkg::RX_HUNT;
          end
        endcase
      end
    end
  end

  // Store writes and frame completion.
  always_comb begin
    wr_o      = '0;
    start_o   = 1'b0;
    if (accept) begin
      if (line_error_i) begin
        // Offset 0 reads as zero until the next first sync byte.
        wr_o.we = 1'b1;
      end else begin
        case (state_q)
          sfrbs_pkg::RX_HUNT: begin
            if (rx_byte_i == sfrbs_pkg::SYNC_FIRST) begin
              wr_o.we   = 1'b1;
              wr_o.data = rx_byte_i;
            end else if (rx_byte_i == sfrbs_pkg::SYNC_SECOND && header_q) begin
              wr_o.we   = 1'b1;
              wr_o.lane = pos_inc[sfrbs_pkg::LANE_W-1:0];
              wr_o.addr = pos_inc[sfrbs_pkg::POS_W-1:sfrbs_pkg::LANE_W];
              wr_o.data = rx_byte_i;
            end
          end
          sfrbs_pkg::RX_FRAME: begin
            wr_o.we   = 1'b1;
            wr_o.lane = pos_inc[sfrbs_pkg::LANE_W-1:0];
            wr_o.addr = pos_inc[sfrbs_pkg::POS_W-1:sfrbs_pkg::LANE_W];
            wr_o.data = rx_byte_i;
            start_o   = (pos_inc == sfrbs_pkg::LAST_POS);
          end
          default: begin
            wr_o.we = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfrbs_pkg::RX_HUNT;
      header_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      header_q <= header_d;
      pos_q    <= pos_d;
    end
  end

endmodule

[src/sfrbs_emitter.sv]
// ----------------------------------------------------------------------------
// sfrbs_emitter: group readout with byte-order swap
// Reads the frame store one group at a time, swaps the bytes and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfrbs_emitter (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  output logic                                            busy_o,
  output logic [sfrbs_pkg::GRP_W-1:0]                     raddr_o,
  input  logic [sfrbs_pkg::LANES-1:0][sfrbs_pkg::BYTE_W-1:0] rdata_i,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  output logic [sfrbs_pkg::TDATA_W-1:0]                   m_axis_tdata,
  output logic                                            m_axis_tlast
);

  sfrbs_pkg::em_state_e             state_q, state_d;
  logic [sfrbs_pkg::GRP_W-1:0]      grp_q, grp_d;
  logic [sfrbs_pkg::GRP_W-1:0]      pend_grp_q;
  logic                             pend_q;
  logic                             issue;
  logic                             valid_q;
  logic [sfrbs_pkg::TDATA_W-1:0]    data_q;
  logic                             last_q;
  logic                             halves;
  logic [sfrbs_pkg::LANES-1:0][sfrbs_pkg::BYTE_W-1:0] swapped;

  // A read goes out only when the output register is free by the time the
  // data returns, so at most one read is in flight.
  assign issue   = (state_q == sfrbs_pkg::EM_RUN) && !pend_q &&
                   (!valid_q || m_axis_tready);
  assign raddr_o = grp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    case (state_q)
      sfrbs_pkg::EM_IDLE: begin
        if (start_i) begin
          state_d = sfrbs_pkg::EM_RUN;
          grp_d   = '0;
        end
      end
      sfrbs_pkg::EM_RUN: begin
        if (issue) begin
          grp_d = sfrbs_pkg::GRP_W'(grp_q + 1'b1);
          if (grp_q == sfrbs_pkg::LAST_GRP) begin
            state_d = sfrbs_pkg::EM_IDLE;
            grp_d   = '0;
          end
        end
      end
      default: begin
        state_d = sfrbs_pkg::EM_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    case (state_q)
      sfrbs_pkg::EM_RUN: busy_o = 1'b1;
      default:           busy_o = 1'b0;
    endcase
  end

  assign halves = (pend_grp_q == '0) || (pend_grp_q >= sfrbs_pkg::HALF_FROM);

  always_comb begin
    if (halves) begin
      swapped[0] = rdata_i[1];
      swapped[1] = rdata_i[0];
      swapped[2] = rdata_i[3];
      swapped[3] = rdata_i[2];
    end else begin
      swapped[0] = rdata_i[3];
      swapped[1] = rdata_i[2];
      swapped[2] = rdata_i[1];
      swapped[3] = rdata_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfrbs_pkg::EM_IDLE;
      grp_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      pend_q  <= issue;
      if (pend_q) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_grp_q <= grp_q;
    end
    if (pend_q) begin
      data_q <= {3'b000, swapped[3], swapped[2], swapped[1], swapped[0], pend_grp_q};
      last_q <= (pend_grp_q == sfrbs_pkg::LAST_GRP);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

[src/sync_frame_receiver_byte_swap.sv]
// ----------------------------------------------------------------------------
// sync_frame_receiver_byte_swap: sync-word frame receiver with byte swap
// Collects 68-byte frames that open with a 0x55 0xAA sync pair and emits
// them as 17 byte-swapped four-byte groups.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one serial byte per item in tdata, with the line
// error flag in tuser. An item with the flag set aborts a frame under way
// and writes zero to offset 0 of the frame store; the header latch survives
// it, so a following 0xAA can reopen a frame.
// Bytes are written into a frame store of four byte lanes (17 words each),
// one byte a cycle, so a byte item is taken every cycle while a frame fills.
// The byte that completes the frame starts the readout: each of the 17
// groups is one read of all four lanes at once, registered in the RAM,
// then a load into the output register. A new read goes out only once the
// previous one has been loaded, so at most one group read is in flight.
// The slave side is held off (tready low) while groups are still being
// read; the last group may wait in the output register while new bytes
// are already taken. A stall on the master side simply holds the readout.
// Reset clears the hunt state, the header latch, the byte position and the
// readout sequencer; the frame store needs no clearing, since every offset
// is written before a frame completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_frame_receiver_byte_swap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] line_error
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] group_index, [12:5] out_byte0,
                                      // [20:13] out_byte1, [28:21] out_byte2,
                                      // [36:29] out_byte3, [39:37] zero
  output logic        m_axis_tlast    // frame_last
);

  sfrbs_pkg::wr_t                                       wr;
  logic                                                 start;
  logic                                                 busy;
  logic [sfrbs_pkg::GRP_W-1:0]                          raddr;
  logic [sfrbs_pkg::LANES-1:0][sfrbs_pkg::BYTE_W-1:0]   rdata;

  sfrbs_rx_ctrl u_rx_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .rx_byte_i     (s_axis_tdata),
    .line_error_i  (s_axis_tuser),
    .busy_i        (busy),
    .wr_o          (wr),
    .start_o       (start)
  );

  // One RAM per byte lane; a frame byte at offset p goes to lane p mod 4,
  // word p div 4, so a whole group is read in one access.
  for (genvar l = 0; l < sfrbs_pkg::LANES; l++) begin : g_lane
    sfrbs_ram #(
      .DATA_W (sfrbs_pkg::BYTE_W),
      .DEPTH  (sfrbs_pkg::GROUPS),
      .ADDR_W (sfrbs_pkg::GRP_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr.we && (wr.lane == sfrbs_pkg::LANE_W'(l))),
      .waddr_i (wr.addr),
      .wdata_i (wr.data),
      .raddr_i (raddr),
      .rdata_o (rdata[l])
    );
  end

  sfrbs_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[src/sfrbs_checker.sv]
// ----------------------------------------------------------------------------
// sfrbs_checker: port-level checks of the sync frame receiver
// Watches the stream ports and flags protocol and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfrbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The last flag marks exactly the final group.
  a_last_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[4:0] == 5'd16)))
    else $error("frame_last does not match the final group");

  // Group indexes stay within the frame.
  a_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:0] <= 5'd16))
    else $error("group index out of range");

  // Input stays held off while groups of a frame remain to be read.
  a_rx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[4:0] != 5'd16) |-> !s_axis_tready)
    else $error("input taken during frame readout");

endmodule

bind sync_frame_receiver_byte_swap sfrbs_checker u_sfrbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
